FILE: hdl/flicker_db_meter_assert.svh
// Assertion macros shared by the flicker meter modules.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef FLICKER_DB_METER_ASSERT_SVH
`define FLICKER_DB_METER_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define FDM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define FDM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fdm_pkg.sv
// Shared types, constants and the threshold table of the flicker meter.
// No dependencies; the modules and interfaces refer to it by scoped names, and the bench imports it.
`timescale 1ns / 1ps

package fdm_pkg;

  localparam int SAMPLE_BITS         = 16;
  localparam int TABLE_ENTRIES       = 47;
  localparam int TABLE_MAX           = 64;
  localparam int WINDOWS_PER_READING = 4;
  localparam int PAIR_ROUNDS         = 5;

  localparam int LUX_W      = 16;
  localparam int CODE_W     = 6;
  localparam int DB_W       = CODE_W + 1;
  localparam int TRY_W      = 3;
  localparam int ROUND_W    = 3;
  localparam int COUNT_W    = 9;
  localparam int EXTRA_W    = 8;
  localparam int MARGIN_W   = 6;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int THRESH_W   = 16;
  localparam int SUM_W      = SAMPLE_BITS + 1;
  localparam int PROD_W     = SAMPLE_BITS + THRESH_W + 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam logic [EXTRA_W-1:0]    EXTRA_RESET   = EXTRA_W'(20);
  localparam logic [MARGIN_W-1:0]   MARGIN_RESET  = MARGIN_W'(3);
  localparam logic [CODE_W-1:0]     RETRY_CODE    = CODE_W'(45);
  localparam logic [CODE_W-1:0]     ZERO_SUM_CODE = CODE_W'(TABLE_ENTRIES - 1);
  localparam logic [TRY_W-1:0]      WINDOW_LIMIT  = TRY_W'(WINDOWS_PER_READING);
  localparam logic [ROUND_W-1:0]    ROUND_LIMIT   = ROUND_W'(PAIR_ROUNDS);
  localparam logic [PROD_W-1:0]     DIFF_SCALE    = PROD_W'(50000);
  localparam logic [FIFO_CNT_W-1:0] FIFO_FULL     = FIFO_CNT_W'(FIFO_DEPTH);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_EXTRA_SAMPLES = 1'b0,
    CFG_AGREE_MARGIN  = 1'b1
  } cfg_index_t;

  // Thresholds in thousandths; entries past the real ones are zero and always met.
  localparam logic [THRESH_W-1:0] THRESH_MILLI [TABLE_MAX] = '{
    16'd54000, 16'd34000, 16'd28000, 16'd24000, 16'd22000, 16'd19230, 16'd17470,
    16'd15380, 16'd13350, 16'd12200, 16'd11110, 16'd9190,  16'd8470,  16'd7620,
    16'd6750,  16'd5650,  16'd5140,  16'd4700,  16'd4540,  16'd3710,  16'd3540,
    16'd2490,  16'd2440,  16'd2380,  16'd2250,  16'd1750,  16'd1670,  16'd1420,
    16'd1280,  16'd1270,  16'd1260,  16'd1250,  16'd1245,  16'd1240,  16'd1230,
    16'd1220,  16'd1200,  16'd1180,  16'd1170,  16'd1160,  16'd1000,  16'd700,
    16'd600,   16'd400,   16'd300,   16'd250,   16'd200,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
  };

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
  } window_t;

  typedef struct packed {
    logic [EXTRA_W-1:0]  extra_samples;
    logic [MARGIN_W-1:0] agree_margin;
  } cfg_t;

endpackage

FILE: hdl/fdm_sample_if.sv
// Stream interface for light samples entering the flicker meter.
// Depends on fdm_pkg for the field width.
`timescale 1ns / 1ps

interface fdm_sample_if;
  logic                      valid;
  logic                      ready;
  logic [fdm_pkg::LUX_W-1:0] lux_sample;

  modport source (output valid, output lux_sample, input ready);
  modport sink (input valid, input lux_sample, output ready);
endinterface

FILE: hdl/fdm_result_if.sv
// Stream interface for flicker codes leaving the flicker meter.
// Depends on fdm_pkg for the field width.
`timescale 1ns / 1ps

interface fdm_result_if;
  logic                     valid;
  logic                     ready;
  logic [fdm_pkg::DB_W-1:0] db_times_two;
  logic                     pair_agreed;

  modport source (output valid, output db_times_two, output pair_agreed, input ready);
  modport sink (input valid, input db_times_two, input pair_agreed, output ready);
endinterface

FILE: hdl/fdm_front.sv
// Front end: takes samples, tracks the window minimum and maximum,
// and pushes each finished window into the queue. Depends on fdm_pkg.
`timescale 1ns / 1ps

module fdm_front (
  input  logic             clk,
  input  logic             rst,
  input  fdm_pkg::cfg_t    cfg,
  fdm_sample_if.sink       samples,
  output logic             push_valid,
  input  logic             push_ready,
  output fdm_pkg::window_t push_data
);

  logic [fdm_pkg::COUNT_W-1:0]     sample_count;
  logic [fdm_pkg::COUNT_W-1:0]     count_inc;
  logic [fdm_pkg::COUNT_W-1:0]     window_len;
  logic [fdm_pkg::SAMPLE_BITS-1:0] window_min;
  logic [fdm_pkg::SAMPLE_BITS-1:0] window_max;
  logic [fdm_pkg::SAMPLE_BITS-1:0] min_next;
  logic [fdm_pkg::SAMPLE_BITS-1:0] max_next;
  logic [fdm_pkg::SAMPLE_BITS-1:0] s;
  logic                            closes;
  logic                            accepted;

  assign s          = samples.lux_sample[fdm_pkg::SAMPLE_BITS-1:0];
  assign count_inc  = sample_count + 1'b1;
  assign window_len = {1'b0, cfg.extra_samples} + 1'b1;
  // Closing depends on state only, so ready never waits on valid.
  assign closes     = (count_inc >= window_len);

  assign samples.ready = !closes || push_ready;
  assign accepted      = samples.valid && samples.ready;

  always_comb begin
    if (sample_count == '0) begin
      min_next = s;
      max_next = s;
    end else begin
      min_next = (s < window_min) ? s : window_min;
      max_next = (s > window_max) ? s : window_max;
    end
  end

  assign push_valid   = samples.valid && closes;
  assign push_data.lo = min_next;
  assign push_data.hi = max_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else if (accepted) begin
      sample_count <= closes ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (accepted) begin
      window_min <= min_next;
      window_max <= max_next;
    end
  end

endmodule

FILE: hdl/fdm_fifo.sv
// Short queue of finished windows between the front and back ends.
// Depends on fdm_pkg for the entry type and depth.
`timescale 1ns / 1ps

`include "flicker_db_meter_assert.svh"

module fdm_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  fdm_pkg::window_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output fdm_pkg::window_t pop_data
);

  fdm_pkg::window_t               mem [fdm_pkg::FIFO_DEPTH];
  logic [fdm_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [fdm_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [fdm_pkg::FIFO_CNT_W-1:0] count;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = (count != fdm_pkg::FIFO_FULL);
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `FDM_ASSERT_ALWAYS(a_fifo_no_overflow, count <= fdm_pkg::FIFO_FULL, "window queue overflow")

endmodule

FILE: hdl/fdm_back.sv
// Back end: a pipeline with one stage per threshold entry grades each window,
// then the reading and pair logic decides on a result. Depends on fdm_pkg.
`timescale 1ns / 1ps

`include "flicker_db_meter_assert.svh"

module fdm_back (
  input  logic             clk,
  input  logic             rst,
  input  fdm_pkg::cfg_t    cfg,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  fdm_pkg::window_t pop_data,
  fdm_result_if.source     results
);

  localparam int ProdW   = fdm_pkg::PROD_W;
  localparam int Stages  = fdm_pkg::TABLE_ENTRIES;
  localparam int CodeW   = fdm_pkg::CODE_W;

  typedef struct packed {
    logic                        valid;
    logic [fdm_pkg::PROD_W-1:0]  lhs;
    logic [fdm_pkg::SUM_W-1:0]   sum;
    logic                        done;
    logic [fdm_pkg::CODE_W-1:0]  code;
  } grade_t;

  grade_t stg      [Stages+1];
  grade_t stg_next [Stages+1];

  logic                            advance;
  logic                            fire;
  logic [fdm_pkg::SAMPLE_BITS-1:0] diff_in;
  logic [fdm_pkg::CODE_W-1:0]      exit_code;

  logic [fdm_pkg::TRY_W-1:0]   window_try, window_try_next, try_inc;
  logic                        pair_half, pair_half_next;
  logic [fdm_pkg::CODE_W-1:0]  first_reading, first_reading_next;
  logic [fdm_pkg::ROUND_W-1:0] pair_round, pair_round_next, round_inc;
  logic [fdm_pkg::CODE_W-1:0]  small_code, code_diff;
  logic                        res_valid, res_valid_next;
  logic [fdm_pkg::DB_W-1:0]    res_db, res_db_next;
  logic                        res_agreed, res_agreed_next;

  // The whole back end holds while a result waits to be taken.
  assign advance   = !res_valid || results.ready;
  assign pop_ready = advance;
  assign diff_in   = pop_data.hi - pop_data.lo;

  always_comb begin
    stg_next[0].valid = pop_valid;
    stg_next[0].lhs   = fdm_pkg::DIFF_SCALE * ProdW'(diff_in);
    stg_next[0].sum   = {1'b0, pop_data.hi} + {1'b0, pop_data.lo};
    stg_next[0].done  = (stg_next[0].sum == '0);
    stg_next[0].code  = fdm_pkg::ZERO_SUM_CODE;
    // Stage k checks threshold entry k-1; the first entry met wins.
    for (int k = 1; k <= Stages; k++) begin
      stg_next[k] = stg[k-1];
      if (!stg[k-1].done &&
          stg[k-1].lhs >= ProdW'(fdm_pkg::THRESH_MILLI[k-1]) * ProdW'(stg[k-1].sum)) begin
        stg_next[k].done = 1'b1;
        stg_next[k].code = CodeW'(k - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= Stages; k++) begin
        stg[k].valid <= 1'b0;
      end
    end else if (advance) begin
      for (int k = 0; k <= Stages; k++) begin
        stg[k] <= stg_next[k];
      end
    end
  end

  // A window that meets no threshold grades as zero.
  assign exit_code = stg[Stages].done ? stg[Stages].code : '0;
  assign fire      = advance && stg[Stages].valid;

  assign try_inc    = window_try + 1'b1;
  assign round_inc  = pair_round + 1'b1;
  assign small_code = (first_reading < exit_code) ? first_reading : exit_code;
  assign code_diff  = (first_reading < exit_code) ? (exit_code - first_reading)
                                                  : (first_reading - exit_code);

  always_comb begin
    window_try_next    = window_try;
    pair_half_next     = pair_half;
    first_reading_next = first_reading;
    pair_round_next    = pair_round;
    res_valid_next     = advance ? 1'b0 : res_valid;
    res_db_next        = res_db;
    res_agreed_next    = res_agreed;
    if (fire) begin
      if (exit_code >= fdm_pkg::RETRY_CODE && try_inc < fdm_pkg::WINDOW_LIMIT) begin
        window_try_next = try_inc;
      end else begin
        window_try_next = '0;
        if (!pair_half) begin
          first_reading_next = exit_code;
          pair_half_next     = 1'b1;
        end else begin
          pair_half_next = 1'b0;
          if ({1'b0, code_diff} < {1'b0, cfg.agree_margin} && small_code != '0) begin
            pair_round_next = '0;
            res_valid_next  = 1'b1;
            res_db_next     = {small_code, 1'b0};
            res_agreed_next = 1'b1;
          end else if (round_inc < fdm_pkg::ROUND_LIMIT) begin
            pair_round_next = round_inc;
          end else begin
            // The pair rounds ran out: report the average in half steps.
            pair_round_next = '0;
            res_valid_next  = 1'b1;
            res_db_next     = {1'b0, first_reading} + {1'b0, exit_code};
            res_agreed_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_try    <= '0;
      pair_half     <= 1'b0;
      first_reading <= '0;
      pair_round    <= '0;
      res_valid     <= 1'b0;
    end else begin
      window_try    <= window_try_next;
      pair_half     <= pair_half_next;
      first_reading <= first_reading_next;
      pair_round    <= pair_round_next;
      res_valid     <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res_db     <= res_db_next;
    res_agreed <= res_agreed_next;
  end

  assign results.valid        = res_valid;
  assign results.db_times_two = res_db;
  assign results.pair_agreed  = res_agreed;

  `FDM_ASSERT_ALWAYS(a_try_bound, window_try < fdm_pkg::WINDOW_LIMIT, "window retry count out of range")
  `FDM_ASSERT_ALWAYS(a_round_bound, pair_round < fdm_pkg::ROUND_LIMIT, "pair round count out of range")
  `FDM_ASSERT_IMPLY(a_result_ends_pair, $rose(res_valid), $past(pair_half) && !pair_half, "result without a finished pair")

endmodule

FILE: hdl/flicker_db_meter.sv
// A result passes the queue, the entry stage, 47 threshold stages and the result
// register after the sample beat closing its last window. Throughput: one sample
// beat per cycle unless a closing beat meets a full queue; the threshold pipeline
// takes one window per cycle and holds as a whole only while a result beat waits
// to be taken. Reset: synchronous and active high; it clears all counters, the queue
// and the pipeline, and loads the register defaults. There is no clearing pass.
`timescale 1ns / 1ps

module flicker_db_meter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fdm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fdm_pkg::CFG_DATA_W-1:0]  cfg_data,
  fdm_sample_if.sink                      samples,
  fdm_result_if.source                    results
);

  fdm_pkg::cfg_t    cfg;
  logic             push_valid;
  logic             push_ready;
  fdm_pkg::window_t push_data;
  logic             pop_valid;
  logic             pop_ready;
  fdm_pkg::window_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.extra_samples <= fdm_pkg::EXTRA_RESET;
      cfg.agree_margin  <= fdm_pkg::MARGIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fdm_pkg::CFG_EXTRA_SAMPLES: begin
          cfg.extra_samples <= cfg_data[fdm_pkg::EXTRA_W-1:0];
        end
        fdm_pkg::CFG_AGREE_MARGIN: begin
          cfg.agree_margin <= cfg_data[fdm_pkg::MARGIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  fdm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .samples    (samples),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  fdm_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  fdm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .results   (results)
  );

endmodule

FILE: bench/tb.sv
// Self-checking bench for flicker_db_meter: streams light samples, computes the flicker
// codes it should produce, and compares them with every result beat.
// Depends on fdm_pkg, fdm_sample_if, fdm_result_if and the flicker_db_meter RTL.
`timescale 1ns / 1ps

module tb;
  import fdm_pkg::*;

  localparam int IDLE_PCT     = 23;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 80;
  localparam int STALL_LIMIT  = 4000;

  typedef struct packed {
    logic [DB_W-1:0] db_times_two;
    logic            pair_agreed;
  } code_beat_t;

  // Tracks windows, readings and pairs, and queues the codes the block owes us.
  class flicker_tracker;
    logic [EXTRA_W-1:0]     span;
    logic [MARGIN_W-1:0]    margin;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [COUNT_W-1:0]     taken;
    logic [TRY_W-1:0]       tries;
    logic                   second_due;
    logic [CODE_W-1:0]      first_code;
    logic [ROUND_W-1:0]     failed_pairs;
    code_beat_t             pending_codes[$];
    int                     errors;

    function new();
      span = EXTRA_RESET;
      margin = MARGIN_RESET;
      lo = '0;
      hi = '0;
      taken = '0;
      tries = '0;
      second_due = 1'b0;
      first_code = '0;
      failed_pairs = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_EXTRA_SAMPLES: span = val[EXTRA_W-1:0];
        CFG_AGREE_MARGIN:  margin = val[MARGIN_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_codes.size();
    endfunction

    function logic [CODE_W-1:0] window_code(logic [SAMPLE_BITS-1:0] wlo,
                                            logic [SAMPLE_BITS-1:0] whi);
      longint unsigned spread;
      longint unsigned total;
      spread = 64'(whi) - 64'(wlo);
      total = 64'(whi) + 64'(wlo);
      if (total == 0) return ZERO_SUM_CODE;
      for (int i = 0; i < TABLE_ENTRIES && i < TABLE_MAX; i++) begin
        if (64'(DIFF_SCALE) * spread >= 64'(THRESH_MILLI[i]) * total) return CODE_W'(i);
      end
      return '0;
    endfunction

    function void take_sample(logic [SAMPLE_BITS-1:0] s);
      logic [CODE_W-1:0] code;
      logic [CODE_W-1:0] smaller;
      logic [CODE_W-1:0] gap;
      code_beat_t beat;
      if (taken == 0) begin
        lo = s;
        hi = s;
      end else begin
        if (s < lo) lo = s;
        if (s > hi) hi = s;
      end
      taken = taken + 1'b1;
      if (int'(taken) < int'(span) + 1) return;
      taken = '0;

      code = window_code(lo, hi);
      tries = tries + 1'b1;
      if (code >= RETRY_CODE && tries < WINDOW_LIMIT) return;
      tries = '0;

      if (!second_due) begin
        first_code = code;
        second_due = 1'b1;
        return;
      end
      second_due = 1'b0;
      smaller = (first_code < code) ? first_code : code;
      gap = (first_code < code) ? code - first_code : first_code - code;
      if (gap < margin && smaller >= 1) begin
        failed_pairs = '0;
        beat.db_times_two = {smaller, 1'b0};
        beat.pair_agreed = 1'b1;
        pending_codes.push_back(beat);
        return;
      end
      failed_pairs = failed_pairs + 1'b1;
      if (failed_pairs < ROUND_LIMIT) return;
      failed_pairs = '0;
      beat.db_times_two = DB_W'(first_code) + DB_W'(code);
      beat.pair_agreed = 1'b0;
      pending_codes.push_back(beat);
    endfunction

    function void check_code(logic [DB_W-1:0] db, logic agreed);
      code_beat_t want;
      if (pending_codes.size() == 0) begin
        $display("%0t: unexpected result beat, actual db_times_two=%0d pair_agreed=%0d",
                 $time, db, agreed);
        errors++;
        return;
      end
      want = pending_codes.pop_front();
      if (db !== want.db_times_two) begin
        $display("%0t: db_times_two mismatch, expected %0d, actual %0d",
                 $time, want.db_times_two, db);
        errors++;
      end
      if (agreed !== want.pair_agreed) begin
        $display("%0t: pair_agreed mismatch, expected %0d, actual %0d",
                 $time, want.pair_agreed, agreed);
        errors++;
      end
    endfunction
  endclass

  localparam logic [LUX_W-1:0] DIRECTED [24] = '{
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd65535, 16'd0, 16'd0, 16'd65535, 16'd1, 16'd1, 16'd2, 16'd1,
    16'h5555, 16'hAAAA, 16'd32768, 16'd32767, 16'd65535, 16'd65535, 16'd100, 16'd95
  };

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  fdm_sample_if sample_bus ();
  fdm_result_if result_bus ();

  flicker_db_meter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (sample_bus),
    .results   (result_bus)
  );

  flicker_tracker tracker = new();

  bit                 no_idle = 1'b0;
  bit                 hold_req = 1'b0;
  int                 noise_pct = 12;
  logic [LUX_W-1:0]   scene_hi = 16'd40000;
  logic [LUX_W-1:0]   scene_lo = 16'd20000;
  bit                 high_half = 1'b0;
  int                 stall_cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Samples mostly follow a light source with a steady modulation depth that changes now
  // and then; the rest is noise, dark and saturated samples.
  function automatic logic [LUX_W-1:0] flicker_sample();
    int unsigned depth;
    int unsigned jit;
    int unsigned v;
    int unsigned r;
    r = $urandom_range(99);
    if (r < noise_pct / 3) return '0;
    if (r < noise_pct / 2) return '1;
    if (r < noise_pct) return LUX_W'($urandom);
    if ($urandom_range(31) == 0) begin
      case ($urandom_range(3))
        0: depth = $urandom_range(14);
        1: depth = $urandom_range(100, 15);
        2: depth = $urandom_range(600, 100);
        default: depth = $urandom_range(1000, 600);
      endcase
      scene_hi = LUX_W'($urandom_range(65535, 16));
      scene_lo = scene_hi - LUX_W'((int'(scene_hi) * depth) / 1000);
    end
    high_half = !high_half;
    jit = $urandom_range(scene_hi >> 10);
    if (high_half) return scene_hi - LUX_W'(jit);
    v = int'(scene_lo) + jit;
    return (v > 65535) ? '1 : LUX_W'(v);
  endfunction

  task automatic send_sample(input logic [LUX_W-1:0] s);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk);
    end
    sample_bus.valid <= 1'b1;
    sample_bus.lux_sample <= s;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
  endtask

  task automatic stream(input int n);
    repeat (n) send_sample(flicker_sample());
  endtask

  // Stops offering samples until every owed code is back and the pipeline has emptied.
  task automatic drain();
    sample_bus.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] extra,
                           input logic [CFG_DATA_W-1:0] margin);
    cfg_we <= 1'b1;
    cfg_index <= CFG_EXTRA_SAMPLES;
    cfg_data <= extra;
    @(posedge clk);
    tracker.write_reg(CFG_EXTRA_SAMPLES, extra);
    cfg_index <= CFG_AGREE_MARGIN;
    cfg_data <= margin;
    @(posedge clk);
    tracker.write_reg(CFG_AGREE_MARGIN, margin);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (sample_bus.valid && sample_bus.ready) tracker.take_sample(sample_bus.lux_sample);
      if (result_bus.valid && result_bus.ready)
        tracker.check_code(result_bus.db_times_two, result_bus.pair_agreed);
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_bus.valid && sample_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      result_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_EXTRA_SAMPLES;
    cfg_data <= '0;
    sample_bus.valid <= 1'b0;
    sample_bus.lux_sample <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Two-sample windows: dark windows that force retries, full swing, steady light
    // below the table, and mid-scale edges.
    configure(8'd1, 8'd3);
    foreach (DIRECTED[i]) send_sample(DIRECTED[i]);
    drain();

    // Shorten the window while one is partly full; it must close on the next sample.
    configure(8'd2, 8'd3);
    send_sample(16'h1234);
    drain();
    configure(8'd0, 8'd0);
    stream(30);
    drain();

    // No idling on either side, and a long receiver hold so the block backs up.
    no_idle = 1'b1;
    configure(8'd1, 8'd46);
    hold_req = 1'b1;
    stream(150);
    drain();
    no_idle = 1'b0;

    configure(8'd3, 8'd1);
    stream(120);
    drain();

    noise_pct = 1;
    configure(8'd255, 8'd63);
    stream(520);
    drain();
    noise_pct = 12;

    configure(8'd2, 8'd5);
    stream(50);
    drain();
    stream(50);
    drain();

    configure(8'd1, 8'd10);
    stream(60);
    drain();

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
